// File: design/rsaks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key setup package
// Shared command codes, status codes and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rsaks_pkg;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_P_BAD       = 3'd1,
		ST_Q_BAD       = 3'd2,
		ST_E_RANGE     = 3'd3,
		ST_NOT_COPRIME = 3'd4,
		ST_NO_D        = 3'd5
	} status_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE    = 4'd0,
		OP_LOAD    = 4'd1,
		OP_INIT_P  = 4'd2,
		OP_INIT_Q  = 4'd3,
		OP_DIV_PR  = 4'd4,
		OP_PR_NEXT = 4'd5,
		OP_MUL_N   = 4'd6,
		OP_SAVE_N  = 4'd7,
		OP_SAVE_T  = 4'd8,
		OP_SET_ST  = 4'd9,
		OP_EU_INIT = 4'd10,
		OP_DIV_EU  = 4'd11,
		OP_MUL_Q   = 4'd12,
		OP_EU_UPD  = 4'd13,
		OP_FIN     = 4'd14
	} op_t;

	// Command from the controller.
	typedef struct packed {
		op_t     op;
		status_t st;
	} cmd_t;

	// Flags from the datapath.
	typedef struct packed {
		logic busy;
		logic v_small;
		logic sq_over;
		logic rem_zero;
		logic e_bad;
		logic r1_zero;
	} flags_t;

endpackage

// File: design/rsaks_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key setup datapath
// Holds the operands, a bit-serial shift-add multiplier, a restoring divider
// and the extended Euclid registers. Acts on one command per cycle.
// ----------------------------------------------------------------------------
module rsaks_datapath #(
	parameter int PRIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsaks_pkg::cmd_t       cmd,
	output rsaks_pkg::flags_t     flags,
	input  logic [PRIME_BITS-1:0] prime_p,
	input  logic [PRIME_BITS-1:0] prime_q,
	input  logic [31:0]           public_exp,
	output logic [31:0]           modulus,
	output logic [31:0]           totient,
	output logic [31:0]           private_exp,
	output logic [2:0]            status
);

	localparam int W  = 2 * PRIME_BITS;
	localparam int SW = PRIME_BITS + 2;
	localparam int EW = (W > 32) ? W : 32;
	localparam int CW = $clog2(W + 1);

	logic [PRIME_BITS-1:0] p_q, q_q, v_q, i_q;
	logic [SW-1:0]         sq_q;
	logic [31:0]           e_q;
	logic [W-1:0]          n_q, t_q, d_q;
	logic [2:0]            st_q;
	logic [W-1:0]          r0_q, r1_q, u0_q, u1_q;
	logic                  k_q;

	// Multiplier state.
	logic [W-1:0]  ma_q, mb_q, acc_q;
	logic [CW-1:0] mcnt_q;
	logic          mbusy_q;

	// Divider state.
	logic [W-1:0]  dq_q, dvs_q;
	logic [W:0]    rem_q;
	logic [CW-1:0] dcnt_q;
	logic          dbusy_q;

	logic [W:0]    rem_sh;
	logic [W-1:0]  u0_mod, inv;

	// One restoring division step.
	assign rem_sh = {rem_q[W-1:0], dq_q[W-1]};

	// Final inverse from the last Euclid coefficient and its sign parity.
	always_comb begin
		u0_mod = (u0_q == t_q) ? '0 : u0_q;
		if (k_q)
			inv = u0_mod;
		else
			inv = (u0_mod == '0) ? '0 : t_q - u0_mod;
	end

	// Serial multiplier: one bit of the multiplier per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mcnt_q  <= '0;
		end else if (cmd.op == rsaks_pkg::OP_MUL_N || cmd.op == rsaks_pkg::OP_SAVE_N ||
			cmd.op == rsaks_pkg::OP_MUL_Q) begin
			mbusy_q <= 1'b1;
			mcnt_q  <= CW'(W);
		end else if (mbusy_q) begin
			mcnt_q  <= mcnt_q - 1'b1;
			mbusy_q <= (mcnt_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rsaks_pkg::OP_MUL_N: begin
				ma_q  <= W'(p_q);
				mb_q  <= W'(q_q);
				acc_q <= '0;
			end
			rsaks_pkg::OP_SAVE_N: begin
				ma_q  <= W'(p_q - 1'b1);
				mb_q  <= W'(q_q - 1'b1);
				acc_q <= '0;
			end
			rsaks_pkg::OP_MUL_Q: begin
				ma_q  <= dq_q;
				mb_q  <= u1_q;
				acc_q <= '0;
			end
			default: begin
				if (mbusy_q) begin
					if (mb_q[0])
						acc_q <= acc_q + ma_q;
					ma_q <= ma_q << 1;
					mb_q <= mb_q >> 1;
				end
			end
		endcase
	end

	// Restoring divider: one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
			dcnt_q  <= '0;
		end else if (cmd.op == rsaks_pkg::OP_DIV_PR || cmd.op == rsaks_pkg::OP_DIV_EU) begin
			dbusy_q <= 1'b1;
			dcnt_q  <= CW'(W);
		end else if (dbusy_q) begin
			dcnt_q  <= dcnt_q - 1'b1;
			dbusy_q <= (dcnt_q != CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rsaks_pkg::OP_DIV_PR: begin
				dq_q  <= W'(v_q);
				dvs_q <= W'(i_q);
				rem_q <= '0;
			end
			rsaks_pkg::OP_DIV_EU: begin
				dq_q  <= r0_q;
				dvs_q <= r1_q;
				rem_q <= '0;
			end
			default: begin
				if (dbusy_q) begin
					if (rem_sh >= {1'b0, dvs_q}) begin
						rem_q <= rem_sh - {1'b0, dvs_q};
						dq_q  <= {dq_q[W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						dq_q  <= {dq_q[W-2:0], 1'b0};
					end
				end
			end
		endcase
	end

	// Operand, trial division, Euclid and result registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rsaks_pkg::OP_LOAD: begin
				p_q  <= prime_p;
				q_q  <= prime_q;
				e_q  <= public_exp;
				n_q  <= '0;
				t_q  <= '0;
				d_q  <= '0;
				st_q <= rsaks_pkg::ST_OK;
			end
			rsaks_pkg::OP_INIT_P, rsaks_pkg::OP_INIT_Q: begin
				v_q  <= (cmd.op == rsaks_pkg::OP_INIT_P) ? p_q : q_q;
				i_q  <= PRIME_BITS'(2);
				sq_q <= SW'(4);
			end
			rsaks_pkg::OP_PR_NEXT: begin
				i_q  <= i_q + 1'b1;
				sq_q <= sq_q + (SW'(i_q) << 1) + SW'(1);
			end
			rsaks_pkg::OP_SAVE_N: n_q <= acc_q;
			rsaks_pkg::OP_SAVE_T: t_q <= acc_q;
			rsaks_pkg::OP_SET_ST: st_q <= cmd.st;
			rsaks_pkg::OP_EU_INIT: begin
				r0_q <= t_q;
				r1_q <= W'(e_q);
				u0_q <= '0;
				u1_q <= W'(1);
				k_q  <= 1'b0;
			end
			rsaks_pkg::OP_EU_UPD: begin
				r0_q <= r1_q;
				r1_q <= rem_q[W-1:0];
				u0_q <= u1_q;
				u1_q <= u0_q + acc_q;
				k_q  <= ~k_q;
			end
			rsaks_pkg::OP_FIN: begin
				if (r0_q != W'(1))
					st_q <= rsaks_pkg::ST_NOT_COPRIME;
				else if (inv == '0 || EW'(inv) == EW'(e_q))
					st_q <= rsaks_pkg::ST_NO_D;
				else begin
					st_q <= rsaks_pkg::ST_OK;
					d_q  <= inv;
				end
			end
			default: ;
		endcase
	end

	// Flags for the controller.
	always_comb begin
		flags.busy     = mbusy_q | dbusy_q;
		flags.v_small  = (v_q < PRIME_BITS'(2));
		flags.sq_over  = (sq_q > SW'(v_q));
		flags.rem_zero = (rem_q == '0);
		flags.e_bad    = (e_q < 32'd3) || (EW'(e_q) >= EW'(t_q));
		flags.r1_zero  = (r1_q == '0);
	end

	assign modulus     = 32'(n_q);
	assign totient     = 32'(t_q);
	assign private_exp = 32'(d_q);
	assign status      = st_q;

endmodule

// File: design/rsaks_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key setup controller
// Sequences the primality tests, the products, the range check and the
// extended Euclid loop, and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module rsaks_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  rsaks_pkg::flags_t    flags,
	output rsaks_pkg::cmd_t      cmd
);

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_PINIT = 14'b00000000000010,
		S_PTEST = 14'b00000000000100,
		S_PDIV  = 14'b00000000001000,
		S_PCHK  = 14'b00000000010000,
		S_MULN  = 14'b00000000100000,
		S_MULT  = 14'b00000001000000,
		S_SAVET = 14'b00000010000000,
		S_RANGE = 14'b00000100000000,
		S_ELOOP = 14'b00001000000000,
		S_EDIV  = 14'b00010000000000,
		S_EMUL  = 14'b00100000000000,
		S_FIN   = 14'b01000000000000,
		S_OUT   = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   on_q_q, on_q_d;

	// Next state and command.
	always_comb begin
		state_d = state_q;
		on_q_d  = on_q_q;
		cmd.op  = rsaks_pkg::OP_NONE;
		cmd.st  = rsaks_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = rsaks_pkg::OP_LOAD;
					on_q_d  = 1'b0;
					state_d = S_PINIT;
				end
			end
			S_PINIT: begin
				cmd.op  = on_q_q ? rsaks_pkg::OP_INIT_Q : rsaks_pkg::OP_INIT_P;
				state_d = S_PTEST;
			end
			S_PTEST: begin
				if (flags.v_small) begin
					cmd.op  = rsaks_pkg::OP_SET_ST;
					cmd.st  = on_q_q ? rsaks_pkg::ST_Q_BAD : rsaks_pkg::ST_P_BAD;
					state_d = S_OUT;
				end else if (flags.sq_over) begin
					if (on_q_q) begin
						cmd.op  = rsaks_pkg::OP_MUL_N;
						state_d = S_MULN;
					end else begin
						on_q_d  = 1'b1;
						state_d = S_PINIT;
					end
				end else begin
					cmd.op  = rsaks_pkg::OP_DIV_PR;
					state_d = S_PDIV;
				end
			end
			S_PDIV: begin
				if (!flags.busy)
					state_d = S_PCHK;
			end
			S_PCHK: begin
				if (flags.rem_zero) begin
					cmd.op  = rsaks_pkg::OP_SET_ST;
					cmd.st  = on_q_q ? rsaks_pkg::ST_Q_BAD : rsaks_pkg::ST_P_BAD;
					state_d = S_OUT;
				end else begin
					cmd.op  = rsaks_pkg::OP_PR_NEXT;
					state_d = S_PTEST;
				end
			end
			S_MULN: begin
				if (!flags.busy) begin
					cmd.op  = rsaks_pkg::OP_SAVE_N;
					state_d = S_MULT;
				end
			end
			S_MULT: begin
				if (!flags.busy)
					state_d = S_SAVET;
			end
			S_SAVET: begin
				cmd.op  = rsaks_pkg::OP_SAVE_T;
				state_d = S_RANGE;
			end
			S_RANGE: begin
				if (flags.e_bad) begin
					cmd.op  = rsaks_pkg::OP_SET_ST;
					cmd.st  = rsaks_pkg::ST_E_RANGE;
					state_d = S_OUT;
				end else begin
					cmd.op  = rsaks_pkg::OP_EU_INIT;
					state_d = S_ELOOP;
				end
			end
			S_ELOOP: begin
				if (flags.r1_zero)
					state_d = S_FIN;
				else begin
					cmd.op  = rsaks_pkg::OP_DIV_EU;
					state_d = S_EDIV;
				end
			end
			S_EDIV: begin
				if (!flags.busy) begin
					cmd.op  = rsaks_pkg::OP_MUL_Q;
					state_d = S_EMUL;
				end
			end
			S_EMUL: begin
				if (!flags.busy) begin
					cmd.op  = rsaks_pkg::OP_EU_UPD;
					state_d = S_ELOOP;
				end
			end
			S_FIN: begin
				cmd.op  = rsaks_pkg::OP_FIN;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			on_q_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			on_q_q  <= on_q_d;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

endmodule

// File: design/rsa_key_setup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key setup unit
// Validates p, q and e, forms n and the totient, and finds the private
// exponent d.
// ----------------------------------------------------------------------------
// One beat in gives one beat out, and the unit works on one item at a time.
// Work is done by a serial divider and a separate serial multiplier, used
// in turn for trial division of p and q up to their square roots, for n and
// the totient, and for each extended Euclid step (at most about 46 steps
// for a 32-bit totient). A status code other than ok means private_exp is
// zero; a failed primality test also zeroes modulus and totient.
module rsa_key_setup_unit #(
	parameter int PRIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PRIME_BITS-1:0] prime_p,
	input  logic [PRIME_BITS-1:0] prime_q,
	input  logic [31:0]           public_exp,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           modulus,
	output logic [31:0]           totient,
	output logic [31:0]           private_exp,
	output logic [2:0]            status
);

	rsaks_pkg::cmd_t   cmd;
	rsaks_pkg::flags_t flags;

	// Sequencer.
	rsaks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	// Arithmetic.
	rsaks_datapath #(
		.PRIME_BITS (PRIME_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.flags       (flags),
		.prime_p     (prime_p),
		.prime_q     (prime_q),
		.public_exp  (public_exp),
		.modulus     (modulus),
		.totient     (totient),
		.private_exp (private_exp),
		.status      (status)
	);

endmodule

// File: design/rsaks_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key setup port checker
// Watches the top-level ports for result consistency and handshake behavior.
// ----------------------------------------------------------------------------
module rsaks_checker #(
	parameter int PRIME_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [PRIME_BITS-1:0] prime_p,
	input logic [PRIME_BITS-1:0] prime_q,
	input logic [31:0]           public_exp,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [31:0]           modulus,
	input logic [31:0]           totient,
	input logic [31:0]           private_exp,
	input logic [2:0]            status
);

	// A waiting result beat holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(modulus) && $stable(totient) &&
		$stable(private_exp) && $stable(status))
		else $error("result beat changed while stalled");

	// A waiting request beat holds still.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(prime_p) && $stable(prime_q) &&
		$stable(public_exp))
		else $error("request beat changed while stalled");

	// A failed key carries no private exponent.
	a_d_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != rsaks_pkg::ST_OK |-> private_exp == 32'd0)
		else $error("private exponent set on failure");

	// A bad factor zeroes the modulus and totient.
	a_factor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == rsaks_pkg::ST_P_BAD || status == rsaks_pkg::ST_Q_BAD)
		|-> modulus == 32'd0 && totient == 32'd0)
		else $error("modulus or totient set for a bad factor");

	// One item at a time: no new beat right after one is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second input beat taken while busy");

endmodule

bind rsa_key_setup_unit rsaks_checker #(.PRIME_BITS(PRIME_BITS)) u_rsaks_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.prime_p     (prime_p),
	.prime_q     (prime_q),
	.public_exp  (public_exp),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.modulus     (modulus),
	.totient     (totient),
	.private_exp (private_exp),
	.status      (status)
);
